>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: same-cycle implication");

// Next-cycle implication, disabled while rst is high.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication");

`endif

>>> sv/rtlu_pkg.sv
// Shared types and constants for the route table lookup/update/dump unit.
// No dependencies; imported by every module of the block but rtlu_ram.
package rtlu_pkg;

   localparam int TABLE_DEPTH_DEF = 8;
   localparam int WORD_W          = 32;
   localparam int METRIC_W        = 5;
   localparam int WORDS_PER_ENTRY = 5;
   localparam int WCNT_W          = 3;

   localparam logic [METRIC_W-1:0] METRIC_INF = 5'd16;

   typedef enum logic [1:0] {
      OPC_LOOKUP  = 2'd0,
      OPC_UPDATE  = 2'd1,
      OPC_REQUEST = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_GATEWAY  = 2'd0,
      KIND_DONE     = 2'd1,
      KIND_RESPONSE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_ADDR    = 2'd0,
      PHASE_METRIC  = 2'd1,
      PHASE_GATEWAY = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      SRC_GATEWAY,
      SRC_ZERO,
      SRC_HEADER,
      SRC_ADDRESS,
      SRC_REQUESTER
   } src_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_TAIL,
      ST_LOOKUP_DONE,
      ST_UPDATE_DONE,
      ST_DUMP_READ,
      ST_DUMP_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic     load_pend_addr;
      logic     load_pend_metric;
      logic     start_lookup;
      logic     start_update;
      logic     load_requester;
      logic     scan_issue;
      logic     idx_inc;
      logic     write_append;
      logic     write_metric;
      logic     out_load;
      src_type  out_src;
      kind_type out_kind;
      logic     out_last;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic idx_last;
      logic found;
      logic metric_lower;
   } dp_status_type;

endpackage

>>> sv/route_table_lookup_update_dump_unit.sv
// Top level of the route table unit: controller plus datapath.
// Depends on rtlu_pkg, rtlu_ctrl, rtlu_dp (and rtlu_ram below it).
//
//   channel | ports          | tdata        | tuser       | tlast
//   --------+----------------+--------------+-------------+-----------
//   request | req_t*  (in)   | value[31:0]  | opcode[1:0] | -
//   result  | rsp_t*  (out)  | word[31:0]   | kind[1:0]   | last
//   config  | csr_*   (in)   | command_version_word on csr_wdata
//
// A lookup or the third update word scans the valid entries (no scan on an
// empty table); first/second update words and opcode 3 need no scan, and a
// table request emits five words per valid entry. The single-write, single-read
// table memories are scanned one entry per cycle.
// Reset clears the entry count, update phase and header register at once;
// there is no clearing pass over the table.
// Results sit in an output register; a stalled rsp_tready holds the
// controller in its done or emit state, while req_tready is high only in idle.
module route_table_lookup_update_dump_unit import rtlu_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [WORD_W-1:0] req_tdata,   // [31:0] value
   input  logic [1:0]        req_tuser,   // [1:0] opcode
   // result channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [WORD_W-1:0] rsp_tdata,   // [31:0] word
   output logic [1:0]        rsp_tuser,   // [1:0] kind
   output logic              rsp_tlast,
   // header word register
   input  logic              csr_wen,
   input  logic [WORD_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;
   kind_type      out_kind;

   rtlu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rtlu_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .req_value (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .out_word  (rsp_tdata),
      .out_kind  (out_kind),
      .out_last  (rsp_tlast)
   );

   assign rsp_tuser = out_kind;

endmodule

>>> sv/rtlu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rtlu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/rtlu_dp.sv
// Datapath: table memories, pending update, scan compare and result payload.
// Depends on rtlu_pkg and rtlu_ram.
module rtlu_dp import rtlu_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wen,
   input  logic [WORD_W-1:0]   csr_wdata,
   input  logic [WORD_W-1:0]   req_value,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   output logic [WORD_W-1:0]   out_word,
   output kind_type            out_kind,
   output logic                out_last
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [WORD_W-1:0]   cfg_ff, cfg_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [WORD_W-1:0]   pend_addr_ff, pend_addr_in;
   logic [METRIC_W-1:0] pend_metric_ff, pend_metric_in;
   logic [WORD_W-1:0]   key_ff, key_in;
   logic [WORD_W-1:0]   upd_gw_ff, upd_gw_in;
   logic [WORD_W-1:0]   requester_ff, requester_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [WORD_W-1:0]   gw_ff, gw_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    found_idx_ff, found_idx_in;
   logic [METRIC_W-1:0] found_metric_ff, found_metric_in;
   logic [WORD_W-1:0]   out_word_ff, out_word_in;
   kind_type            out_kind_ff, out_kind_in;
   logic                out_last_ff, out_last_in;

   logic [WORD_W-1:0]   addr_rdata, gw_rdata;
   logic [METRIC_W-1:0] met_rdata;
   logic [IDX_W-1:0]    wr_idx;
   logic                met_we;
   logic                hit;

   assign wr_idx = cmd.write_append ? count_ff[IDX_W-1:0] : found_idx_ff;
   assign met_we = cmd.write_append | cmd.write_metric;

   rtlu_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_addr_ram (
      .clock   (clock),
      .wr_en   (cmd.write_append),
      .wr_addr (wr_idx),
      .wr_data (pend_addr_ff),
      .rd_addr (idx_ff),
      .rd_data (addr_rdata)
   );

   rtlu_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_gw_ram (
      .clock   (clock),
      .wr_en   (cmd.write_append),
      .wr_addr (wr_idx),
      .wr_data (upd_gw_ff),
      .rd_addr (idx_ff),
      .rd_data (gw_rdata)
   );

   rtlu_ram #(.WIDTH(METRIC_W), .DEPTH(TABLE_DEPTH)) u_met_ram (
      .clock   (clock),
      .wr_en   (met_we),
      .wr_addr (wr_idx),
      .wr_data (pend_metric_ff),
      .rd_addr (idx_ff),
      .rd_data (met_rdata)
   );

   assign hit = cmp_vld_ff && (addr_rdata == key_ff);

   always_comb begin
      cfg_in          = csr_wen ? csr_wdata : cfg_ff;
      count_in        = cmd.write_append ? count_ff + CNT_W'(1) : count_ff;
      pend_addr_in    = cmd.load_pend_addr ? req_value : pend_addr_ff;
      pend_metric_in  = pend_metric_ff;
      if (cmd.load_pend_metric) begin
         // metrics above infinity saturate
         pend_metric_in = (req_value > WORD_W'(METRIC_INF)) ? METRIC_INF
                                                             : req_value[METRIC_W-1:0];
      end
      key_in          = key_ff;
      upd_gw_in       = upd_gw_ff;
      requester_in    = cmd.load_requester ? req_value : requester_ff;
      idx_in          = idx_ff;
      cmp_vld_in      = cmd.scan_issue;
      cmp_idx_in      = cmd.scan_issue ? idx_ff : cmp_idx_ff;
      gw_in           = gw_ff;
      found_in        = found_ff;
      found_idx_in    = found_idx_ff;
      found_metric_in = found_metric_ff;

      if (cmd.start_lookup || cmd.start_update) begin
         key_in   = cmd.start_update ? pend_addr_ff : req_value;
         gw_in    = '0;
         found_in = 1'b0;
         idx_in   = '0;
      end
      if (cmd.start_update) begin
         upd_gw_in = req_value;
      end
      if (cmd.load_requester) begin
         idx_in = '0;
      end
      if (cmd.scan_issue || cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      // lookup keeps the last hit, update keeps the first
      if (hit) begin
         gw_in = gw_rdata;
         if (!found_ff) begin
            found_in        = 1'b1;
            found_idx_in    = cmp_idx_ff;
            found_metric_in = met_rdata;
         end
      end

      out_word_in = out_word_ff;
      out_kind_in = out_kind_ff;
      out_last_in = out_last_ff;
      if (cmd.out_load) begin
         out_kind_in = cmd.out_kind;
         out_last_in = cmd.out_last;
         case (cmd.out_src)
            SRC_GATEWAY:   out_word_in = gw_ff;
            SRC_ZERO:      out_word_in = '0;
            SRC_HEADER:    out_word_in = cfg_ff + WORD_W'(met_rdata);
            SRC_ADDRESS:   out_word_in = addr_rdata;
            SRC_REQUESTER: out_word_in = requester_ff;
            default:       out_word_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff     <= '0;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff    <= pend_addr_in;
      pend_metric_ff  <= pend_metric_in;
      key_ff          <= key_in;
      upd_gw_ff       <= upd_gw_in;
      requester_ff    <= requester_in;
      idx_ff          <= idx_in;
      cmp_idx_ff      <= cmp_idx_in;
      gw_ff           <= gw_in;
      found_ff        <= found_in;
      found_idx_ff    <= found_idx_in;
      found_metric_ff <= found_metric_in;
      out_word_ff     <= out_word_in;
      out_kind_ff     <= out_kind_in;
      out_last_ff     <= out_last_in;
   end

   assign status.count_zero   = (count_ff == '0);
   assign status.count_full   = (count_ff == CNT_W'(TABLE_DEPTH));
   assign status.idx_last     = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign status.found        = found_ff;
   assign status.metric_lower = (found_metric_ff > pend_metric_ff);

   assign out_word = out_word_ff;
   assign out_kind = out_kind_ff;
   assign out_last = out_last_ff;

endmodule

>>> sv/rtlu_ctrl.sv
// Controller: sequences lookup scans, update writes and table dumps.
// Depends on rtlu_pkg; drives rtlu_dp through dp_cmd_type.
module rtlu_ctrl import rtlu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic              upd_ff, upd_in;
   logic [WCNT_W-1:0] wcnt_ff, wcnt_in;
   logic              valid_ff, valid_in;
   logic              out_free;
   logic              accept;

   assign out_free = !valid_ff || rsp_tready;
   assign accept   = req_tvalid && req_tready;

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      upd_in     = upd_ff;
      wcnt_in    = wcnt_ff;
      cmd        = '0;
      req_tready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               case (req_tuser)
                  OPC_LOOKUP: begin
                     cmd.start_lookup = 1'b1;
                     upd_in           = 1'b0;
                     state_in         = status.count_zero ? ST_LOOKUP_DONE : ST_SCAN;
                  end
                  OPC_UPDATE: begin
                     case (phase_ff)
                        PHASE_ADDR: begin
                           cmd.load_pend_addr = 1'b1;
                           phase_in           = PHASE_METRIC;
                        end
                        PHASE_METRIC: begin
                           cmd.load_pend_metric = 1'b1;
                           phase_in             = PHASE_GATEWAY;
                        end
                        PHASE_GATEWAY: begin
                           cmd.start_update = 1'b1;
                           phase_in         = PHASE_ADDR;
                           upd_in           = 1'b1;
                           state_in = status.count_zero ? ST_UPDATE_DONE : ST_SCAN;
                        end
                        default: phase_in = PHASE_ADDR;
                     endcase
                  end
                  OPC_REQUEST: begin
                     cmd.load_requester = 1'b1;
                     if (!status.count_zero) begin
                        state_in = ST_DUMP_READ;
                     end
                  end
                  default: ;  // unused opcode: dropped
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.idx_last) begin
               state_in = ST_SCAN_TAIL;
            end
         end
         ST_SCAN_TAIL: begin
            // last compare lands this cycle
            state_in = upd_ff ? ST_UPDATE_DONE : ST_LOOKUP_DONE;
         end
         ST_LOOKUP_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = SRC_GATEWAY;
               cmd.out_kind = KIND_GATEWAY;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_UPDATE_DONE: begin
            if (out_free) begin
               cmd.write_metric = status.found && status.metric_lower;
               cmd.write_append = !status.found && !status.count_full;
               cmd.out_load     = 1'b1;
               cmd.out_src      = SRC_ZERO;
               cmd.out_kind     = KIND_DONE;
               cmd.out_last     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_DUMP_READ: begin
            wcnt_in  = '0;
            state_in = ST_DUMP_EMIT;
         end
         ST_DUMP_EMIT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_RESPONSE;
               case (wcnt_ff)
                  WCNT_W'(0): cmd.out_src = SRC_HEADER;
                  WCNT_W'(1): cmd.out_src = SRC_ADDRESS;
                  WCNT_W'(4): cmd.out_src = SRC_REQUESTER;
                  default:    cmd.out_src = SRC_ZERO;
               endcase
               if (wcnt_ff == WCNT_W'(WORDS_PER_ENTRY - 1)) begin
                  cmd.out_last = status.idx_last;
                  if (status.idx_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     cmd.idx_inc = 1'b1;
                     state_in    = ST_DUMP_READ;
                  end
               end else begin
                  wcnt_in = wcnt_ff + WCNT_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PHASE_ADDR;
         upd_ff   <= 1'b0;
         wcnt_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         upd_ff   <= upd_in;
         wcnt_ff  <= wcnt_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

>>> sv/rtlu_chk.sv
// Port-level checker for the route table unit, bound to the top level.
// Depends on rtlu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rtlu_chk import rtlu_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [WORD_W-1:0] rsp_tdata,
   input logic [1:0]        rsp_tuser,
   input logic              rsp_tlast
);

   logic [WORD_W+2:0] rsp_bus;

   assign rsp_bus = {rsp_tlast, rsp_tuser, rsp_tdata};

   // a stalled word holds
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_bus))

   // lookup and done results are single words
   `CHK_IMPLY(a_single_last, clock, reset, rsp_tvalid && rsp_tuser != KIND_RESPONSE, rsp_tlast)

   // done carries zero
   `CHK_IMPLY(a_done_zero, clock, reset, rsp_tvalid && rsp_tuser == KIND_DONE, rsp_tdata == '0)

   // output register empty after reset
   `CHK_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind route_table_lookup_update_dump_unit rtlu_chk u_rtlu_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
